// ===== rtl/tpsp_pkg.sv =====
// shared types and constants for the touch panel sample processor
package tpsp_pkg;

  localparam int SMP_W      = 12;
  localparam int SUM_W      = 16;
  localparam int AXIS_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int OP_W       = 3;
  localparam int DIV_STEPS  = SUM_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int SLOT_W     = 3;

  localparam logic [3:0]        SAMPLES_PER_READ = 4'd15;
  localparam logic [SMP_W-1:0]  DIV_AVG          = 12'd15;
  localparam logic [SMP_W:0]    PRESSURE_BASE    = 13'd4096;
  localparam logic [SMP_W:0]    TOUCH_THRESHOLD  = 13'd80;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANGE = 3'd7;

  // rotation codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_BOTH = 2'd1;
  localparam logic [1:0] ROT_Y    = 2'd2;
  localparam logic [1:0] ROT_X    = 2'd3;

  // divider operations, in order of execution
  localparam logic [OP_W-1:0] OP_AVG_X  = 3'd0;
  localparam logic [OP_W-1:0] OP_AVG_Y  = 3'd1;
  localparam logic [OP_W-1:0] OP_AVG_Z  = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP_Y = 3'd3;
  localparam logic [OP_W-1:0] OP_POS_Y  = 3'd4;
  localparam logic [OP_W-1:0] OP_STEP_X = 3'd5;
  localparam logic [OP_W-1:0] OP_POS_X  = 3'd6;

  // event slots, in order of emission
  localparam logic [SLOT_W-1:0] SLOT_FIRST  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_SECOND = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_SYNC_A = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_TOUCH  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_SYNC_B = 3'd4;

  typedef enum logic [1:0] {
    EV_FIRST  = 2'd0,
    EV_SECOND = 2'd1,
    EV_SYNC   = 2'd2,
    EV_TOUCH  = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_EVAL,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/touch_panel_sample_processor.sv =====
// touch panel sample processor: averaging, calibration scaling and event output
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  in       | in_valid, in_stall, in_sample_x/y/z2    | words in
//  out      | out_valid, out_stall, out_event_kind,   | words out
//           | out_event_value, out_last_event         |
//  cfg      | cfg_we, cfg_index, cfg_wdata            | writes in
//
// a word that does not complete a group of fifteen is taken while in_stall stays low
// the fifteenth word runs seven divisions on one shared bit-serial divider,
// each a load state then restoring steps, then the evaluate state; in_stall stays high through all of it
// and through up to five event words, one per cycle when out_stall is low
// rst_n is synchronous; it resets sums, counters, touch history and the configuration registers
// out_stall holds the output word and the emission of the next; a pending output word does not stop accumulation
module touch_panel_sample_processor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tpsp_pkg::SMP_W-1:0]   in_sample_x,
  input  logic [tpsp_pkg::SMP_W-1:0]   in_sample_y,
  input  logic [tpsp_pkg::SMP_W-1:0]   in_sample_z2,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_event_kind,
  output logic [tpsp_pkg::SMP_W-1:0]   out_event_value,
  output logic                         out_last_event,
  input  logic                         cfg_we,
  input  logic [tpsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpsp_pkg::SMP_W-1:0]   cfg_wdata
);

  // configuration
  logic [1:0]                 rot_r;
  logic [tpsp_pkg::SMP_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [tpsp_pkg::SMP_W-1:0] width_r, height_r, min_chg_r;

  // control and history
  tpsp_pkg::state_t            state_r, state_nxt;
  logic [3:0]                  cnt_r, cnt_nxt;
  logic [tpsp_pkg::SUM_W-1:0]  sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt, sum_z_r, sum_z_nxt;
  logic [tpsp_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [tpsp_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [tpsp_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        mv_r, mv_nxt, chg_r, chg_nxt;
  logic                        was_tch_r, was_tch_nxt;
  logic signed [tpsp_pkg::AXIS_W-1:0] last_fst_r, last_fst_nxt, last_snd_r, last_snd_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // divider and payload
  logic [tpsp_pkg::SMP_W-1:0]  rem_r, rem_nxt;
  logic [tpsp_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [tpsp_pkg::SMP_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic [tpsp_pkg::SMP_W-1:0]  stpx_r, stpx_nxt, stpy_r, stpy_nxt;
  logic [tpsp_pkg::SMP_W-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic [tpsp_pkg::SMP_W-1:0]  fst_r, fst_nxt, snd_r, snd_nxt;
  logic                        tch_r, tch_nxt;
  logic [1:0]                  out_kind_r, out_kind_nxt;
  logic [tpsp_pkg::SMP_W-1:0]  out_value_r, out_value_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [tpsp_pkg::SUM_W-1:0]  dvd;
  logic [tpsp_pkg::SMP_W-1:0]  dvs;
  logic [tpsp_pkg::SMP_W+1:0]  trial;
  logic [tpsp_pkg::SMP_W:0]    shifted;
  logic                        qbit;
  logic [tpsp_pkg::SMP_W-1:0]  qres, fst_w, snd_w;
  logic                        tch_w, mv_w, out_free;
  logic signed [tpsp_pkg::AXIS_W:0] dfst, dsnd, afst, asnd;

  assign in_stall        = (state_r != tpsp_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_event_value = out_value_r;
  assign out_last_event  = out_last_r;
  assign out_free        = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r     <= tpsp_pkg::ROT_NONE;
      min_x_r   <= 12'd0;
      max_x_r   <= 12'd4095;
      min_y_r   <= 12'd0;
      max_y_r   <= 12'd4095;
      width_r   <= 12'd480;
      height_r  <= 12'd320;
      min_chg_r <= 12'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        tpsp_pkg::REG_ROTATION:   rot_r     <= cfg_wdata[1:0];
        tpsp_pkg::REG_MIN_X:      min_x_r   <= cfg_wdata;
        tpsp_pkg::REG_MAX_X:      max_x_r   <= cfg_wdata;
        tpsp_pkg::REG_MIN_Y:      min_y_r   <= cfg_wdata;
        tpsp_pkg::REG_MAX_Y:      max_y_r   <= cfg_wdata;
        tpsp_pkg::REG_WIDTH:      width_r   <= cfg_wdata;
        tpsp_pkg::REG_HEIGHT:     height_r  <= cfg_wdata;
        tpsp_pkg::REG_MIN_CHANGE: min_chg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // divider operand select
  always_comb begin
    dvd = quo_r;
    dvs = tpsp_pkg::DIV_AVG;
    case (op_r)
      tpsp_pkg::OP_AVG_X:  dvd = sum_x_r;
      tpsp_pkg::OP_AVG_Y:  dvd = sum_y_r;
      tpsp_pkg::OP_AVG_Z:  dvd = sum_z_r;
      tpsp_pkg::OP_STEP_Y: begin
        dvd = {4'd0, max_y_r - min_y_r};
        dvs = height_r;
      end
      tpsp_pkg::OP_POS_Y: begin
        dvd = {4'd0, ay_r - min_y_r};
        dvs = stpy_r;
      end
      tpsp_pkg::OP_STEP_X: begin
        dvd = {4'd0, max_x_r - min_x_r};
        dvs = width_r;
      end
      tpsp_pkg::OP_POS_X: begin
        dvd = {4'd0, ax_r - min_x_r};
        dvs = stpx_r;
      end
      default: ;
    endcase
  end

  // one restoring step per cycle
  assign shifted = {rem_r, quo_r[tpsp_pkg::SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};
  assign qbit    = !trial[tpsp_pkg::SMP_W+1];
  assign qres    = {quo_r[tpsp_pkg::SMP_W-2:0], qbit};

  // clamp and scale, touch and movement decisions
  // a zero span gives a zero step, which selects the full height or width unless the average is below the minimum
  always_comb begin
    if (ay_r < min_y_r)                                      fst_w = '0;
    else if (ay_r > max_y_r || stpy_r == '0 || height_r == '0) fst_w = height_r;
    else                                                     fst_w = qy_r;
    if (ax_r < min_x_r)                                      snd_w = '0;
    else if (ax_r > max_x_r || stpx_r == '0 || width_r == '0)  snd_w = width_r;
    else                                                     snd_w = qx_r;
    tch_w = (tpsp_pkg::PRESSURE_BASE - {1'b0, az_r}) > tpsp_pkg::TOUCH_THRESHOLD;
    dfst  = $signed({2'b00, fst_w}) - {last_fst_r[tpsp_pkg::AXIS_W-1], last_fst_r};
    dsnd  = $signed({2'b00, snd_w}) - {last_snd_r[tpsp_pkg::AXIS_W-1], last_snd_r};
    afst  = dfst[tpsp_pkg::AXIS_W] ? -dfst : dfst;
    asnd  = dsnd[tpsp_pkg::AXIS_W] ? -dsnd : dsnd;
    mv_w  = tch_w && (afst > $signed({2'b00, min_chg_r}) ||
                      asnd > $signed({2'b00, min_chg_r}));
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    sum_z_nxt     = sum_z_r;
    op_nxt        = op_r;
    dcnt_nxt      = dcnt_r;
    slot_nxt      = slot_r;
    mv_nxt        = mv_r;
    chg_nxt       = chg_r;
    was_tch_nxt   = was_tch_r;
    last_fst_nxt  = last_fst_r;
    last_snd_nxt  = last_snd_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    stpx_nxt      = stpx_r;
    stpy_nxt      = stpy_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    fst_nxt       = fst_r;
    snd_nxt       = snd_r;
    tch_nxt       = tch_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      tpsp_pkg::ST_IDLE: begin
        if (in_valid) begin
          sum_x_nxt = sum_x_r + {4'd0, in_sample_x};
          sum_y_nxt = sum_y_r + {4'd0, in_sample_y};
          sum_z_nxt = sum_z_r + {4'd0, in_sample_z2};
          cnt_nxt   = cnt_r + 4'd1;
          if (cnt_nxt == tpsp_pkg::SAMPLES_PER_READ) begin
            cnt_nxt   = '0;
            op_nxt    = tpsp_pkg::OP_AVG_X;
            state_nxt = tpsp_pkg::ST_LOAD;
          end
        end
      end
      tpsp_pkg::ST_LOAD: begin
        rem_nxt   = '0;
        quo_nxt   = dvd;
        dcnt_nxt  = '0;
        state_nxt = tpsp_pkg::ST_RUN;
      end
      tpsp_pkg::ST_RUN: begin
        rem_nxt  = qbit ? trial[tpsp_pkg::SMP_W-1:0] : shifted[tpsp_pkg::SMP_W-1:0];
        quo_nxt  = {quo_r[tpsp_pkg::SUM_W-2:0], qbit};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == tpsp_pkg::DCNT_W'(tpsp_pkg::DIV_STEPS - 1)) begin
          case (op_r)
            tpsp_pkg::OP_AVG_X:
              ax_nxt = (rot_r == tpsp_pkg::ROT_BOTH || rot_r == tpsp_pkg::ROT_X) ? ~qres : qres;
            tpsp_pkg::OP_AVG_Y:
              ay_nxt = (rot_r == tpsp_pkg::ROT_BOTH || rot_r == tpsp_pkg::ROT_Y) ? ~qres : qres;
            tpsp_pkg::OP_AVG_Z:  az_nxt   = qres;
            tpsp_pkg::OP_STEP_Y: stpy_nxt = qres;
            tpsp_pkg::OP_POS_Y:  qy_nxt   = qres;
            tpsp_pkg::OP_STEP_X: stpx_nxt = qres;
            tpsp_pkg::OP_POS_X:  qx_nxt   = qres;
            default: ;
          endcase
          if (op_r == tpsp_pkg::OP_POS_X) begin
            state_nxt = tpsp_pkg::ST_EVAL;
          end else begin
            op_nxt    = op_r + 1'b1;
            state_nxt = tpsp_pkg::ST_LOAD;
          end
        end
      end
      tpsp_pkg::ST_EVAL: begin
        sum_x_nxt   = '0;
        sum_y_nxt   = '0;
        sum_z_nxt   = '0;
        fst_nxt     = fst_w;
        snd_nxt     = snd_w;
        tch_nxt     = tch_w;
        mv_nxt      = mv_w;
        chg_nxt     = (tch_w != was_tch_r);
        was_tch_nxt = tch_w;
        if (mv_w) begin
          last_fst_nxt = $signed({1'b0, fst_w});
          last_snd_nxt = $signed({1'b0, snd_w});
        end
        slot_nxt  = mv_w ? tpsp_pkg::SLOT_FIRST : tpsp_pkg::SLOT_TOUCH;
        state_nxt = (mv_w || tch_w != was_tch_r) ? tpsp_pkg::ST_EMIT : tpsp_pkg::ST_IDLE;
      end
      tpsp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b0;
          case (slot_r)
            tpsp_pkg::SLOT_FIRST: begin
              out_kind_nxt  = tpsp_pkg::EV_FIRST;
              out_value_nxt = fst_r;
            end
            tpsp_pkg::SLOT_SECOND: begin
              out_kind_nxt  = tpsp_pkg::EV_SECOND;
              out_value_nxt = snd_r;
            end
            tpsp_pkg::SLOT_TOUCH: begin
              out_kind_nxt  = tpsp_pkg::EV_TOUCH;
              out_value_nxt = {11'd0, tch_r};
            end
            default: out_kind_nxt = tpsp_pkg::EV_SYNC;
          endcase
          if ((slot_r == tpsp_pkg::SLOT_SYNC_A && !chg_r) || slot_r == tpsp_pkg::SLOT_SYNC_B) begin
            out_last_nxt = 1'b1;
            state_nxt    = tpsp_pkg::ST_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      default: state_nxt = tpsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpsp_pkg::ST_IDLE;
      cnt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      op_r        <= tpsp_pkg::OP_AVG_X;
      dcnt_r      <= '0;
      slot_r      <= tpsp_pkg::SLOT_FIRST;
      mv_r        <= 1'b0;
      chg_r       <= 1'b0;
      was_tch_r   <= 1'b0;
      last_fst_r  <= '1;
      last_snd_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_z_r     <= sum_z_nxt;
      op_r        <= op_nxt;
      dcnt_r      <= dcnt_nxt;
      slot_r      <= slot_nxt;
      mv_r        <= mv_nxt;
      chg_r       <= chg_nxt;
      was_tch_r   <= was_tch_nxt;
      last_fst_r  <= last_fst_nxt;
      last_snd_r  <= last_snd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    az_r        <= az_nxt;
    stpx_r      <= stpx_nxt;
    stpy_r      <= stpy_nxt;
    qx_r        <= qx_nxt;
    qy_r        <= qy_nxt;
    fst_r       <= fst_nxt;
    snd_r       <= snd_nxt;
    tch_r       <= tch_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  // group completion starts the divider with cleared count
  a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && cnt_r == 4'd14) |=>
      (state_r == tpsp_pkg::ST_LOAD && cnt_r == 4'd0))
    else $error("group completion did not start divider");

  // sums are empty at the start of a group
  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpsp_pkg::ST_IDLE && cnt_r == 4'd0) |->
      (sum_x_r == '0 && sum_y_r == '0 && sum_z_r == '0))
    else $error("sums not cleared at group start");

  // the closing word of a sample is always a sync
  a_last_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == tpsp_pkg::EV_SYNC))
    else $error("last word is not a sync");

  // touch word carries a single flag bit
  a_touch_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == tpsp_pkg::EV_TOUCH) |-> (out_value_r[11:1] == '0))
    else $error("touch word value out of range");

  // divider operation index stays in its sequence
  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpsp_pkg::ST_RUN) |-> (op_r <= tpsp_pkg::OP_POS_X))
    else $error("divider operation out of range");

endmodule
